### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Shared types and constants of the frame parser's front end, queue and back end.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  // Default depth of the queue between front end and back end.
  localparam int QUEUE_DEPTH = 2;

  // Length codes that announce an extended length field.
  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  // Header sizes in bytes.
  localparam logic [3:0] HDR_BASE_LEN  = 4'd2;
  localparam logic [3:0] HDR_LEN16_ADD = 4'd2;
  localparam logic [3:0] HDR_LEN64_ADD = 4'd8;
  localparam logic [3:0] HDR_KEY_LEN   = 4'd4;

  // Result kinds, as they appear on the result channel.
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_SHORT   = 2'd2,
    KIND_OVERRUN = 2'd3
  } kind_t;

  // Parser phases of the front end.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  // Header flags: FIN, RSV1..RSV3, opcode, mask bit.
  typedef struct packed {
    logic       fin;
    logic [2:0] rsv;
    logic [3:0] opcode;
    logic       mask;
  } hdr_flags_t;

  // One classified transaction handed from the front end to the back end.
  typedef struct packed {
    kind_t      op;
    logic       last;
    logic [7:0] data;
    hdr_flags_t flags;
    logic [63:0] length;
    logic [31:0] key;
  } entry_t;

endpackage

### rtl/wsfp_in_if.sv
// ----------------------------------------------------------------------------
// Frame parser input channel
// Valid/ready channel carrying one received buffer byte per transaction.
// ----------------------------------------------------------------------------
interface wsfp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [31:0] buffer_length;

  modport source (output valid, output data_byte, output first_byte,
                  output buffer_length, input ready);
  modport sink (input valid, input data_byte, input first_byte,
                input buffer_length, output ready);
endinterface

### rtl/wsfp_out_if.sv
// ----------------------------------------------------------------------------
// Frame parser result channel
// Valid/ready channel carrying one parser result per transaction.
// ----------------------------------------------------------------------------
interface wsfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        fin;
  logic [2:0]  reserved_bits;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output kind, output fin, output reserved_bits,
                  output opcode, output masked, output payload_length,
                  output payload_byte, output last, input ready);
  modport sink (input valid, input kind, input fin, input reserved_bits,
                input opcode, input masked, input payload_length,
                input payload_byte, input last, output ready);
endinterface

### rtl/wsfp_front.sv
// ----------------------------------------------------------------------------
// Frame parser front end
// Tracks the header phase of each byte and pushes classified entries.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_first_byte,
  input  logic [31:0]        in_buffer_length,
  input  logic               q_full,
  output logic               push_o,
  output wsfp_pkg::entry_t   entry_o
);

  wsfp_pkg::phase_t     phase_r, phase_nxt, cur_phase;
  logic [3:0]           pos_r, pos_nxt, cur_pos, new_pos;
  logic [3:0]           hlen_r, hlen_nxt, cur_hlen, hlen_calc, ext_end;
  wsfp_pkg::hdr_flags_t flags_r, flags_nxt, cur_flags;
  logic [63:0]          ext_r, ext_nxt, cur_ext;
  logic [31:0]          key_r, key_nxt, cur_key;
  logic [31:0]          rem_r, rem_nxt, cur_rem, new_rem;
  logic [63:0]          pay_left_r, pay_left_nxt;
  logic [6:0]           code;
  logic                 accept;
  logic                 hdr_done;
  logic                 pay_last;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign code     = in_data_byte[6:0];

  // A new buffer restarts the frame in the same cycle as its first byte.
  always_comb begin
    cur_phase = in_first_byte ? wsfp_pkg::PH_HEADER : phase_r;
    cur_pos   = in_first_byte ? 4'd0 : pos_r;
    cur_hlen  = in_first_byte ? wsfp_pkg::HDR_BASE_LEN : hlen_r;
    cur_flags = in_first_byte ? wsfp_pkg::hdr_flags_t'('0) : flags_r;
    cur_ext   = in_first_byte ? 64'd0 : ext_r;
    cur_key   = in_first_byte ? 32'd0 : key_r;
    cur_rem   = in_first_byte ? in_buffer_length : rem_r;
  end

  assign new_pos = cur_pos + 4'd1;
  assign new_rem = cur_rem - 32'd1;
  assign ext_end = cur_hlen - (cur_flags.mask ? wsfp_pkg::HDR_KEY_LEN : 4'd0);
  assign pay_last = (pay_left_r == 64'd1);

  always_comb begin
    hlen_calc = wsfp_pkg::HDR_BASE_LEN;
    if (code == wsfp_pkg::LEN16_CODE) begin
      hlen_calc = hlen_calc + wsfp_pkg::HDR_LEN16_ADD;
    end else if (code == wsfp_pkg::LEN64_CODE) begin
      hlen_calc = hlen_calc + wsfp_pkg::HDR_LEN64_ADD;
    end
    if (in_data_byte[7]) begin
      hlen_calc = hlen_calc + wsfp_pkg::HDR_KEY_LEN;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    hlen_nxt     = hlen_r;
    flags_nxt    = flags_r;
    ext_nxt      = ext_r;
    key_nxt      = key_r;
    rem_nxt      = rem_r;
    pay_left_nxt = pay_left_r;
    push_o       = 1'b0;
    entry_o      = '0;
    hdr_done     = 1'b0;
    if (accept) begin
      phase_nxt = cur_phase;
      pos_nxt   = cur_pos;
      hlen_nxt  = cur_hlen;
      flags_nxt = cur_flags;
      ext_nxt   = cur_ext;
      key_nxt   = cur_key;
      rem_nxt   = cur_rem;
      case (cur_phase)
        wsfp_pkg::PH_HEADER: begin
          if (cur_pos == 4'd0) begin
            if (cur_rem < 32'd2) begin
              push_o     = 1'b1;
              entry_o.op = wsfp_pkg::KIND_SHORT;
              entry_o.last = 1'b1;
              phase_nxt  = wsfp_pkg::PH_IDLE;
            end else begin
              flags_nxt.fin    = in_data_byte[7];
              flags_nxt.rsv    = in_data_byte[6:4];
              flags_nxt.opcode = in_data_byte[3:0];
              flags_nxt.mask   = 1'b0;
              rem_nxt = new_rem;
              pos_nxt = new_pos;
            end
          end else if (cur_pos == 4'd1) begin
            // The remaining count still includes this byte.
            if (cur_rem < {28'd0, hlen_calc - 4'd1}) begin
              push_o       = 1'b1;
              entry_o.op   = wsfp_pkg::KIND_SHORT;
              entry_o.last = 1'b1;
              phase_nxt    = wsfp_pkg::PH_IDLE;
            end else begin
              flags_nxt.mask = in_data_byte[7];
              ext_nxt  = (code >= wsfp_pkg::LEN16_CODE) ? 64'd0 : {57'd0, code};
              hlen_nxt = hlen_calc;
              rem_nxt  = new_rem;
              pos_nxt  = new_pos;
              hdr_done = (hlen_calc == wsfp_pkg::HDR_BASE_LEN);
            end
          end else begin
            if (cur_pos < ext_end) begin
              ext_nxt = {cur_ext[55:0], in_data_byte};
            end else begin
              key_nxt = {cur_key[23:0], in_data_byte};
            end
            rem_nxt  = new_rem;
            pos_nxt  = new_pos;
            hdr_done = (new_pos == cur_hlen);
          end
          if (hdr_done) begin
            push_o         = 1'b1;
            entry_o.flags  = flags_nxt;
            entry_o.length = ext_nxt;
            entry_o.key    = key_nxt;
            if (ext_nxt > {32'd0, rem_nxt}) begin
              entry_o.op   = wsfp_pkg::KIND_OVERRUN;
              entry_o.last = 1'b1;
              phase_nxt    = wsfp_pkg::PH_IDLE;
            end else begin
              entry_o.op   = wsfp_pkg::KIND_HEADER;
              entry_o.last = (ext_nxt == 64'd0);
              phase_nxt    = (ext_nxt == 64'd0) ? wsfp_pkg::PH_IDLE : wsfp_pkg::PH_PAYLOAD;
              pay_left_nxt = ext_nxt;
            end
          end
        end
        wsfp_pkg::PH_PAYLOAD: begin
          push_o         = 1'b1;
          entry_o.op     = wsfp_pkg::KIND_PAYLOAD;
          entry_o.last   = pay_last;
          entry_o.data   = in_data_byte;
          entry_o.flags  = flags_r;
          entry_o.length = ext_r;
          entry_o.key    = key_r;
          pay_left_nxt   = pay_left_r - 64'd1;
          if (pay_last) begin
            phase_nxt = wsfp_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsfp_pkg::PH_IDLE;
      pos_r      <= 4'd0;
      hlen_r     <= wsfp_pkg::HDR_BASE_LEN;
      flags_r    <= '0;
      ext_r      <= 64'd0;
      key_r      <= 32'd0;
      rem_r      <= 32'd0;
      pay_left_r <= 64'd0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      hlen_r     <= hlen_nxt;
      flags_r    <= flags_nxt;
      ext_r      <= ext_nxt;
      key_r      <= key_nxt;
      rem_r      <= rem_nxt;
      pay_left_r <= pay_left_nxt;
    end
  end

  `ASSERT_IMPLIES(a_payload_left, phase_r == wsfp_pkg::PH_PAYLOAD, pay_left_r != 64'd0, "payload phase with no bytes left")
  `ASSERT_NEXT(a_last_goes_idle, push_o && entry_o.last, phase_r == wsfp_pkg::PH_IDLE, "frame did not end after its last result")

endmodule

### rtl/wsfp_queue.sv
// ----------------------------------------------------------------------------
// Frame parser entry queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfp_queue #(
  parameter int Depth = wsfp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wsfp_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output wsfp_pkg::entry_t q_entry
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  wsfp_pkg::entry_t mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == DepthCnt);
  assign q_valid = (cnt_r != '0);
  assign q_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into a full queue")
  `ASSERT_ALWAYS(a_no_underflow, !(pop && !q_valid), "pop from an empty queue")
  `ASSERT_ALWAYS(a_count_range, cnt_r <= DepthCnt, "queue count beyond depth")

endmodule

### rtl/wsfp_back.sv
// ----------------------------------------------------------------------------
// Frame parser back end
// Unmasks payload bytes and holds each result in the output register.
// ----------------------------------------------------------------------------
module wsfp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  wsfp_pkg::entry_t q_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic             out_fin,
  output logic [2:0]       out_reserved_bits,
  output logic [3:0]       out_opcode,
  output logic             out_masked,
  output logic [63:0]      out_payload_length,
  output logic [7:0]       out_payload_byte,
  output logic             out_last
);

  logic        valid_r, valid_nxt;
  logic [1:0]  key_idx_r, key_idx_nxt;
  logic [7:0]  key_byte;
  logic        with_hdr;
  logic [1:0]  kind_r;
  logic        fin_r, masked_r, last_r;
  logic [2:0]  rsv_r;
  logic [3:0]  opcode_r;
  logic [63:0] length_r;
  logic [7:0]  byte_r;

  assign pop = q_valid && (!valid_r || out_ready);

  // Key byte for payload index mod 4, first key byte in the top bits.
  always_comb begin
    case (key_idx_r)
      2'd0:    key_byte = q_entry.key[31:24];
      2'd1:    key_byte = q_entry.key[23:16];
      2'd2:    key_byte = q_entry.key[15:8];
      default: key_byte = q_entry.key[7:0];
    endcase
    if (!q_entry.flags.mask) begin
      key_byte = 8'd0;
    end
  end

  assign with_hdr = (q_entry.op != wsfp_pkg::KIND_SHORT);

  always_comb begin
    valid_nxt   = valid_r;
    key_idx_nxt = key_idx_r;
    if (pop) begin
      valid_nxt = 1'b1;
      if (q_entry.op == wsfp_pkg::KIND_HEADER) begin
        key_idx_nxt = 2'd0;
      end else if (q_entry.op == wsfp_pkg::KIND_PAYLOAD) begin
        key_idx_nxt = key_idx_r + 2'd1;
      end
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      key_idx_r <= 2'd0;
    end else begin
      valid_r   <= valid_nxt;
      key_idx_r <= key_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r   <= q_entry.op;
      fin_r    <= with_hdr && q_entry.flags.fin;
      rsv_r    <= with_hdr ? q_entry.flags.rsv : 3'd0;
      opcode_r <= with_hdr ? q_entry.flags.opcode : 4'd0;
      masked_r <= with_hdr && q_entry.flags.mask;
      length_r <= with_hdr ? q_entry.length : 64'd0;
      byte_r   <= (q_entry.op == wsfp_pkg::KIND_PAYLOAD) ? (q_entry.data ^ key_byte) : 8'd0;
      last_r   <= q_entry.last;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = kind_r;
  assign out_fin            = fin_r;
  assign out_reserved_bits  = rsv_r;
  assign out_opcode         = opcode_r;
  assign out_masked         = masked_r;
  assign out_payload_length = length_r;
  assign out_payload_byte   = byte_r;
  assign out_last           = last_r;

endmodule

### rtl/websocket_frame_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Streaming RFC 6455 frame header parser and payload unmasker.
// ----------------------------------------------------------------------------
// The parser takes one received buffer byte per transaction, one transaction
// per clock cycle when not stalled, and gives at most one result per byte. The
// first byte of a buffer is flagged and carries the buffer length. The header
// (FIN, RSV1..RSV3, opcode, mask bit, 7/16/64-bit length, masking key) yields
// no result until its last byte, which answers with a header result, or with
// a payload-overrun error when the payload does not fit in the buffer. A
// buffer too short for the header answers with a header-too-short error at
// the byte that reveals it. Each payload byte then answers with one result,
// unmasked with key byte (index mod 4), and the last result of a frame has
// last set. Bytes after the frame, and bytes before any first byte, are
// dropped. A flagged first byte in the middle of a frame abandons it silently.
// After its byte is accepted, a result passes through the front end's
// classification into the entry queue, then through the back end's unmasking
// into the output register. The queue holds QueueDepth entries, so the input
// keeps taking bytes while a result waits on the output, and the input stalls
// only once the queue is full.
// ----------------------------------------------------------------------------
module websocket_frame_parser #(
  parameter int QueueDepth = wsfp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  wsfp_in_if.sink     in_ch,
  wsfp_out_if.source  out_ch
);

  // Front end to queue.
  logic             q_push;
  wsfp_pkg::entry_t q_push_entry;
  logic             q_full;

  // Queue to back end.
  logic             q_pop;
  logic             q_valid;
  wsfp_pkg::entry_t q_entry;

  // The front end keeps all header state: phase, header position, flags,
  // extended length, key, the bytes left in the buffer and the payload count.
  wsfp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_data_byte     (in_ch.data_byte),
    .in_first_byte    (in_ch.first_byte),
    .in_buffer_length (in_ch.buffer_length),
    .q_full           (q_full),
    .push_o           (q_push),
    .entry_o          (q_push_entry)
  );

  // Entries wait here when the result side stalls.
  wsfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  // The back end walks the key bytes and registers each result.
  wsfp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_entry            (q_entry),
    .pop                (q_pop),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_kind           (out_ch.kind),
    .out_fin            (out_ch.fin),
    .out_reserved_bits  (out_ch.reserved_bits),
    .out_opcode         (out_ch.opcode),
    .out_masked         (out_ch.masked),
    .out_payload_length (out_ch.payload_length),
    .out_payload_byte   (out_ch.payload_byte),
    .out_last           (out_ch.last)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame parser testbench
// Feeds received buffers one byte per transaction into the frame parser and
// checks every result against a cycle-free model of the parser kept here.
// Directed cases cover the special frames first. Backpressure follows, and
// then random traffic under three idling schemes.
// ----------------------------------------------------------------------------
module tb_top;
  import wsfp_pkg::*;

  // Cycles in which the result side refuses everything during the backpressure test.
  localparam int HOLD_CYCLES     = 120;
  // Cycles without any accepted transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT  = 1000;
  // Counted buffer bytes per random traffic phase.
  localparam int ITEMS_PER_PHASE = 400;
  // Extra cycles after the last result.
  localparam int SETTLE_CYCLES   = 10;
  localparam int DRAIN_LIMIT     = 5000;

  // How the payload length is encoded in the header.
  typedef enum int {
    FORM_7,
    FORM_16,
    FORM_64
  } len_form_t;

  // One parser result, field by field as it leaves the result channel.
  typedef struct packed {
    kind_t       kind;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] length;
    logic [7:0]  data;
    logic        is_last;
  } parse_result_t;

  logic clk;
  logic rst_n;

  wsfp_in_if  in_ch();
  wsfp_out_if out_ch();

  websocket_frame_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Results the parser owes us, oldest first.
  parse_result_t frame_results_due[$];
  // Bytes of the buffer currently being assembled by a test.
  logic [7:0]    frame_bytes[$];

  // Shadow copy of the parser's frame state.
  phase_t      ph;
  logic [3:0]  hdr_pos;
  logic [3:0]  hdr_len;
  hdr_flags_t  flags;
  logic [63:0] ext_len;
  logic [31:0] mkey;
  logic [63:0] pay_idx;
  logic [31:0] remaining;

  int src_idle_pct;
  int sink_idle_pct;
  int hold_requests;
  int holds_served;
  int hold_left;
  int stall_cycles;
  int mismatch_count;
  int counted_bytes;
  int buffers_sent;
  int results_checked;
  int kind_seen[4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow parser. It is advanced once per accepted input transaction and
  // queues the result, if any, that the byte is expected to produce.
  // --------------------------------------------------------------------------
  function automatic void post_result(kind_t k, logic with_hdr, logic [7:0] data,
                                      logic is_last);
    parse_result_t r;
    r.kind    = k;
    r.fin     = with_hdr ? flags.fin    : 1'b0;
    r.rsv     = with_hdr ? flags.rsv    : 3'd0;
    r.opcode  = with_hdr ? flags.opcode : 4'd0;
    r.masked  = with_hdr ? flags.mask   : 1'b0;
    r.length  = with_hdr ? ext_len      : 64'd0;
    r.data    = data;
    r.is_last = is_last;
    frame_results_due.push_back(r);
  endfunction

  function automatic void decode_frame_byte(logic [7:0] data, logic is_first,
                                            logic [31:0] buf_len);
    logic [6:0]  code;
    logic [3:0]  ext_end;
    logic [31:0] key_shift;
    logic        done;
    // A flagged first byte always restarts the frame, abandoning any
    // frame in flight without a result.
    if (is_first) begin
      ph        = PH_HEADER;
      hdr_pos   = 4'd0;
      hdr_len   = HDR_BASE_LEN;
      flags     = '0;
      ext_len   = 64'd0;
      mkey      = 32'd0;
      pay_idx   = 64'd0;
      remaining = buf_len;
    end
    case (ph)
      PH_HEADER: begin
        if (hdr_pos == 4'd0) begin
          // Fewer than two bytes cannot hold even the base header.
          if (remaining < 32'd2) begin
            ph = PH_IDLE;
            post_result(KIND_SHORT, 1'b0, 8'd0, 1'b1);
            return;
          end
          flags.fin    = data[7];
          flags.rsv    = data[6:4];
          flags.opcode = data[3:0];
        end else if (hdr_pos == 4'd1) begin
          // The second byte fixes the header size, so the short-buffer check
          // for the whole header happens here. The current byte still counts.
          code       = data[6:0];
          flags.mask = data[7];
          hdr_len    = HDR_BASE_LEN
                     + ((code == LEN16_CODE) ? HDR_LEN16_ADD :
                        (code == LEN64_CODE) ? HDR_LEN64_ADD : 4'd0)
                     + (flags.mask ? HDR_KEY_LEN : 4'd0);
          ext_len    = (code >= LEN16_CODE) ? 64'd0 : {57'd0, code};
          if (remaining < hdr_len - 1) begin
            ph = PH_IDLE;
            post_result(KIND_SHORT, 1'b0, 8'd0, 1'b1);
            return;
          end
        end else begin
          // Extended length bytes come first, big-endian, then the key.
          ext_end = hdr_len - (flags.mask ? HDR_KEY_LEN : 4'd0);
          if (hdr_pos < ext_end) begin
            ext_len = {ext_len[55:0], data};
          end else begin
            mkey = {mkey[23:0], data};
          end
        end
        remaining = remaining - 1;
        hdr_pos   = hdr_pos + 4'd1;
        if (hdr_pos == hdr_len) begin
          if (ext_len > {32'd0, remaining}) begin
            ph = PH_IDLE;
            post_result(KIND_OVERRUN, 1'b1, 8'd0, 1'b1);
          end else begin
            // An empty payload closes the frame on the header itself.
            ph = (ext_len == 64'd0) ? PH_IDLE : PH_PAYLOAD;
            post_result(KIND_HEADER, 1'b1, 8'd0, ext_len == 64'd0);
          end
        end
      end
      PH_PAYLOAD: begin
        key_shift = flags.mask ? (mkey >> (8 * (3 - pay_idx[1:0]))) : 32'd0;
        if (remaining != 32'd0) begin
          remaining = remaining - 1;
        end
        pay_idx = pay_idx + 1;
        done    = (pay_idx >= ext_len);
        if (done) begin
          ph = PH_IDLE;
        end
        post_result(KIND_PAYLOAD, 1'b1, data ^ key_shift[7:0], done);
      end
      default: begin
        // Idle: stray bytes are dropped.
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side. One byte goes out per call; the sender may idle before it,
  // and the call returns at the edge where the transaction is accepted.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] data, input logic is_first,
                           input logic [31:0] buf_len);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= data;
    in_ch.first_byte    <= is_first;
    in_ch.buffer_length <= buf_len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_frame_byte(data, is_first, buf_len);
  endtask

  // Sends the first n_send bytes of frame_bytes as one buffer. The length is
  // only meaningful with the first byte, so later bytes carry random junk in
  // that field. Only the first n_counted bytes count as useful traffic.
  task automatic send_buffer(input logic [31:0] declared, input int n_send,
                             input int n_counted);
    for (int i = 0; i < n_send; i++) begin
      send_byte(frame_bytes[i], i == 0, (i == 0) ? declared : $urandom);
    end
    counted_bytes += (n_counted < n_send) ? n_counted : n_send;
    buffers_sent++;
  endtask

  // Starts a new frame in frame_bytes with the given header and returns its size.
  function automatic int build_header(hdr_flags_t fl, len_form_t form,
                                      logic [63:0] plen, logic [31:0] key);
    logic [6:0] code;
    frame_bytes.delete();
    code = (form == FORM_16) ? LEN16_CODE :
           (form == FORM_64) ? LEN64_CODE : plen[6:0];
    frame_bytes.push_back({fl.fin, fl.rsv, fl.opcode});
    frame_bytes.push_back({fl.mask, code});
    if (form == FORM_16) begin
      frame_bytes.push_back(plen[15:8]);
      frame_bytes.push_back(plen[7:0]);
    end else if (form == FORM_64) begin
      for (int i = 7; i >= 0; i--) frame_bytes.push_back(plen[8*i +: 8]);
    end
    if (fl.mask) begin
      for (int i = 3; i >= 0; i--) frame_bytes.push_back(key[8*i +: 8]);
    end
    return frame_bytes.size();
  endfunction

  function automatic void add_payload(int n);
    for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // --------------------------------------------------------------------------
  // Result side. Ready is redrawn every cycle unless a hold-off is running.
  // A hold-off is requested by bumping hold_requests; it is counted here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_ch.ready <= 1'b0;
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic check_field(input string field_name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
      mismatch_count++;
    end
  endtask

  // Every accepted result is compared with the oldest outstanding one.
  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frame_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                 $time, out_ch.kind, out_ch.payload_byte);
        mismatch_count++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("kind",           64'(want.kind),    64'(out_ch.kind));
        check_field("fin",            64'(want.fin),     64'(out_ch.fin));
        check_field("reserved_bits",  64'(want.rsv),     64'(out_ch.reserved_bits));
        check_field("opcode",         64'(want.opcode),  64'(out_ch.opcode));
        check_field("masked",         64'(want.masked),  64'(out_ch.masked));
        check_field("payload_length", want.length,       out_ch.payload_length);
        check_field("payload_byte",   64'(want.data),    64'(out_ch.payload_byte));
        check_field("last",           64'(want.is_last), 64'(out_ch.last));
        kind_seen[want.kind]++;
        results_checked++;
      end
    end
  end

  // Watchdog: too long without any transaction on either channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL websocket_frame_parser");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Bytes that arrive with no buffer started are dropped without a result.
  task automatic test_orphan_bytes();
    send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
    send_byte(8'h00, 1'b0, 32'h0000_0000);
  endtask

  // Buffers too short for the header: lengths of zero and one fail at the
  // first byte, while a masked 16-bit header in three bytes fails at the second.
  task automatic test_short_buffers();
    frame_bytes = '{8'h81};
    send_buffer(32'd0, 1, 1);
    frame_bytes = '{8'h82};
    send_buffer(32'd1, 1, 1);
    frame_bytes = '{8'h89, 8'hFE};
    send_buffer(32'd3, 2, 2);
  endtask

  // An empty control frame closes on its header. After it comes a masked one-byte frame.
  task automatic test_empty_and_masked();
    frame_bytes = '{8'h8A, 8'h00};
    send_buffer(32'd2, 2, 2);
    frame_bytes = '{8'h81, 8'h81, 8'h37, 8'hFA, 8'h21, 8'h3D, 8'h5A};
    send_buffer(32'd7, 7, 7);
  endtask

  // A frame cut short by a new first byte gives nothing more. The new buffer
  // sets every flag but mask, has an all-ones 64-bit length, and so overruns.
  task automatic test_abandon_and_overrun();
    frame_bytes = '{8'h01, 8'h05, 8'hAA};
    send_buffer(32'd7, 3, 3);
    frame_bytes = '{8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buffer(32'd10, 10, 10);
  endtask

  // The result side stalls for a long stretch while a long masked frame is
  // offered back to back, so the queue fills and the input must stall.
  task automatic test_backpressure();
    hdr_flags_t fl;
    int hlen;
    src_idle_pct  = 0;
    sink_idle_pct <= 0;
    hold_requests <= hold_requests + 1;
    fl.fin    = 1'b1;
    fl.rsv    = 3'd0;
    fl.opcode = 4'h2;
    fl.mask   = 1'b1;
    hlen = build_header(fl, FORM_7, 64'd40, $urandom);
    add_payload(40);
    send_buffer(hlen + 40, hlen + 40, hlen + 40);
  endtask

  // One random buffer. Most are well formed; the rest are truncated headers,
  // payload overruns and frames abandoned part way through.
  task automatic random_frame();
    logic [8:0]  flag_bits;
    hdr_flags_t  fl;
    len_form_t   form;
    logic [63:0] plen;
    logic [31:0] declared;
    int          hlen, total, n_send, scenario, pick;
    scenario  = $urandom_range(99);
    flag_bits = 9'($urandom_range(511));
    fl        = flag_bits;
    // Mostly short payloads, now and then a few hundred bytes.
    if ($urandom_range(19) == 0) begin
      plen = 64'($urandom_range(300));
    end else begin
      plen = 64'($urandom_range(24));
    end
    pick = $urandom_range(9);
    if (plen >= 64'd126) begin
      form = (pick < 7) ? FORM_16 : FORM_64;
    end else begin
      form = (pick < 6) ? FORM_7 : (pick < 8) ? FORM_16 : FORM_64;
    end
    // Overruns also use huge 16-bit and 64-bit lengths.
    if (scenario >= 80 && scenario < 90) begin
      case ($urandom_range(2))
        0: begin
          form = FORM_64;
          plen = {$urandom, $urandom};
        end
        1: begin
          form = FORM_16;
          plen = 64'($urandom_range(65535));
        end
        default: begin
        end
      endcase
      if (plen == 64'd0) begin
        plen = 64'd1;
      end
    end
    hlen = build_header(fl, form, plen, $urandom);

    if (scenario < 70) begin
      // Well formed, sometimes with trailing bytes and a generous length.
      add_payload(int'(plen));
      if ($urandom_range(3) == 0) begin
        add_payload($urandom_range(1, 3));
      end
      total    = frame_bytes.size();
      declared = total;
      if ($urandom_range(9) == 0) begin
        declared = $urandom;
        if (declared < total) begin
          declared = total;
        end
      end
      send_buffer(declared, total, hlen + int'(plen));
      // Stray bytes between buffers must be dropped.
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(255)), 1'b0, $urandom);
      end
    end else if (scenario < 80) begin
      // Declared length shorter than the header.
      declared = $urandom_range(hlen - 1);
      n_send   = (declared == 0) ? 1 : int'(declared);
      send_buffer(declared, n_send, (n_send < 2) ? n_send : 2);
    end else if (scenario < 90) begin
      // Header fits, payload does not.
      add_payload(4);
      if (plen > 64'hFFFF_FFFF) begin
        declared = $urandom;
      end else if (plen > 64'd64) begin
        declared = hlen + $urandom_range(63);
      end else begin
        declared = hlen + $urandom_range(int'(plen) - 1);
      end
      if (declared < hlen) begin
        declared = hlen;
      end
      send_buffer(declared, frame_bytes.size(), hlen);
    end else begin
      // Cut anywhere after the first byte; the next buffer abandons it.
      add_payload(int'(plen));
      total  = frame_bytes.size();
      n_send = $urandom_range(1, total - 1);
      send_buffer(total, n_send, n_send);
    end
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct);
    int goal;
    src_idle_pct  = src_pct;
    sink_idle_pct <= sink_pct;
    goal = counted_bytes + ITEMS_PER_PHASE;
    while (counted_bytes < goal) random_frame();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= 8'd0;
    in_ch.first_byte    <= 1'b0;
    in_ch.buffer_length <= 32'd0;
    src_idle_pct    = 0;
    sink_idle_pct   = 0;
    hold_requests   = 0;
    counted_bytes   = 0;
    buffers_sent    = 0;
    ph        = PH_IDLE;
    hdr_pos   = 4'd0;
    hdr_len   = HDR_BASE_LEN;
    flags     = '0;
    ext_len   = 64'd0;
    mkey      = 32'd0;
    pay_idx   = 64'd0;
    remaining = 32'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_orphan_bytes();
    test_short_buffers();
    test_empty_and_masked();
    test_abandon_and_overrun();
    test_backpressure();
    test_random_traffic(28, 47);
    test_random_traffic(47, 28);
    test_random_traffic(0, 0);
    // The last byte was accepted at this edge; stop offering it.
    in_ch.valid <= 1'b0;

    waited = 0;
    while (frame_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (frame_results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, frame_results_due.size());
    end

    $display("Sent %0d buffers with %0d frame bytes, clean and with idling on both sides.",
             buffers_sent, counted_bytes);
    $display("Checked %0d results: %0d headers, %0d payload, %0d short, %0d overrun.",
             results_checked, kind_seen[KIND_HEADER], kind_seen[KIND_PAYLOAD],
             kind_seen[KIND_SHORT], kind_seen[KIND_OVERRUN]);
    if (mismatch_count == 0 && frame_results_due.size() == 0) begin
      $display("PASS websocket_frame_parser");
    end else begin
      $display("FAIL websocket_frame_parser");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/wsfp_pkg.sv
rtl/wsfp_in_if.sv
rtl/wsfp_out_if.sv
rtl/wsfp_front.sv
rtl/wsfp_queue.sv
rtl/wsfp_back.sv
rtl/websocket_frame_parser.sv
tb/tb_top.sv
